// File: src/bpt_pkg.sv
// ----------------------------------------------------------------------------
// bpt_pkg - shared types and constants of the byte pattern text parser
// character codes, default buffer size and controller/datapath interface
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpt_pkg;

   // default quoted text buffer depth
   localparam int MAX_TEXT_DEFAULT = 32;

   localparam logic [7:0] CH_QUESTION = 8'h3F;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] MASK_EXACT  = 8'hFF;
   localparam logic [7:0] MASK_WILD   = 8'h00;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;     // latch an input beat
      logic step;        // apply one tokeniser step
      logic store;       // append char to the quote buffer
      logic quote_end;   // close the quote, drop the buffer
      logic idx_clr;
      logic idx_inc;
      logic mem_rd;      // read buffer at the index
      logic emit_rd;     // emit buffer read data as an exact byte
      logic rep_start;   // unclosed quote at end: drop the quote, start reparse
      logic release_mid; // pass a held result on, not final
      logic flush_nib;   // emit a waiting nibble
      logic finish;      // final result out, state back to reset
   } bpt_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic quote_open;
      logic char_quote;
      logic len_zero;
      logic idx_last;
      logic end_flag;
      logic step_emit;
      logic step_again;
      logic push_ok;
      logic out_free;
      logic pend;
   } bpt_sts_type;

endpackage

`default_nettype wire

// File: src/byte_pattern_text_parser_core.sv
// ----------------------------------------------------------------------------
// byte_pattern_text_parser_core - streaming byte pattern text parser
// turns pattern text, one character per beat, into (value, mask) byte pairs
// ----------------------------------------------------------------------------
// usage
//  - req channel: one text character per beat, req_end_of_text on the final one
//  - rsp channel: one (value, mask) pair per beat; rsp_last marks the final
//    result of a string, an end marker (rsp_has_byte low) stands in when the
//    final character yields nothing
//  - an ordinary character is taken by a capture and one tokeniser step,
//    both issued by the controller; a character that flushes a waiting
//    nibble takes a second tokeniser step
//  - a closing quote reads each buffered byte through the buffer read port
//    and then emits it; an unclosed quote at end of text is reparsed by
//    reading each buffered character and running tokeniser steps on it
//  - one result is held back inside so the final one can carry rsp_last
//  - a stalled receiver holds the output register and, once the held slot
//    is also full, stops the tokeniser; no result is lost
//  - reset clears tokeniser and quote state and empties both result registers
//  - quoted text beyond MAX_TEXT characters is dropped, and
//    rsp_text_overflow is set on every later result of the same string
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module byte_pattern_text_parser_core #(
   parameter int MAX_TEXT = bpt_pkg::MAX_TEXT_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   // request beats
   input  wire        req_valid,
   output logic       req_ready,
   input  wire [7:0]  req_char_code,
   input  wire        req_end_of_text,
   // result beats
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [7:0] rsp_pattern_value,
   output logic [7:0] rsp_pattern_mask,
   output logic       rsp_has_byte,
   output logic       rsp_text_overflow,
   output logic       rsp_last
);
   import bpt_pkg::*;

   // command and status between sequencer and datapath
   bpt_cmd_type cmd;
   bpt_sts_type sts;

   // state machine: character steps, quote flush, end-of-text reparse
   bpt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // tokeniser, quote buffer memory, held result and output register
   bpt_datapath #(
      .MAX_TEXT (MAX_TEXT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_char_code     (req_char_code),
      .req_end_of_text   (req_end_of_text),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_pattern_value (rsp_pattern_value),
      .rsp_pattern_mask  (rsp_pattern_mask),
      .rsp_has_byte      (rsp_has_byte),
      .rsp_text_overflow (rsp_text_overflow),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

// File: src/bpt_datapath.sv
// ----------------------------------------------------------------------------
// bpt_datapath - tokeniser state, quote buffer and result registers
// one tokeniser step per command, one held result ahead of the output stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpt_datapath #(
   parameter int MAX_TEXT = bpt_pkg::MAX_TEXT_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire [7:0]            req_char_code,
   input  wire                  req_end_of_text,
   input  bpt_pkg::bpt_cmd_type cmd,
   output bpt_pkg::bpt_sts_type sts,
   input  wire                  rsp_ready,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_pattern_value,
   output logic [7:0]           rsp_pattern_mask,
   output logic                 rsp_has_byte,
   output logic                 rsp_text_overflow,
   output logic                 rsp_last
);
   import bpt_pkg::*;

   localparam int AW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
   localparam int LW = $clog2(MAX_TEXT + 1);

   logic [7:0]    mem [MAX_TEXT];
   logic [7:0]    rd_data_ff;

   logic [7:0]    char_ff, char_in;
   logic          end_ff, end_in;
   logic [3:0]    nib_ff, nib_in;
   logic          pend_ff, pend_in;
   logic          qs_ff, qs_in;
   logic          inside_ff, inside_in;
   logic [LW-1:0] len_ff, len_in;
   logic          ovf_ff, ovf_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          rep_ff, rep_in;

   logic          hold_valid_ff, hold_valid_in;
   logic [7:0]    hold_value_ff, hold_value_in;
   logic [7:0]    hold_mask_ff, hold_mask_in;
   logic          hold_ovf_ff, hold_ovf_in;

   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_value_ff, out_value_in;
   logic [7:0]    out_mask_ff, out_mask_in;
   logic          out_has_ff, out_has_in;
   logic          out_ovf_ff, out_ovf_in;
   logic          out_last_ff, out_last_in;

   // tokeniser step
   logic [7:0]    s_c;
   logic          s_hv;
   logic [3:0]    s_h;
   logic          s_sep;
   logic          s_emit;
   logic [7:0]    s_val;
   logic [7:0]    s_mask;
   logic          s_again;
   logic          s_nib_load;
   logic          s_pend_set;
   logic          s_pend_clr;
   logic          s_qs_next;
   logic          s_open;

   logic          em_valid;
   logic [7:0]    em_val;
   logic [7:0]    em_mask;
   logic          out_free;
   logic          push_ok;

   always_comb begin
      // during a reparse the tokeniser works on buffer read data
      s_c = rep_ff ? rd_data_ff : char_ff;
      s_hv = 1'b0;
      s_h = s_c[3:0];
      if (s_c inside {[8'h30:8'h39]}) begin
         s_hv = 1'b1;
      end else if (s_c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         s_hv = 1'b1;
         s_h = s_c[3:0] + 4'd9;
      end
      s_sep = s_c inside {CH_SPACE, [8'h09:8'h0D], CH_COMMA, CH_SEMI};

      s_emit = 1'b0;
      s_val = 8'h00;
      s_mask = MASK_WILD;
      s_again = 1'b0;
      s_nib_load = 1'b0;
      s_pend_set = 1'b0;
      s_pend_clr = 1'b0;
      s_qs_next = qs_ff;
      s_open = 1'b0;
      if (pend_ff) begin
         // a waiting nibble completes or is flushed first
         s_emit = 1'b1;
         s_mask = MASK_EXACT;
         s_pend_clr = 1'b1;
         if (s_hv) begin
            s_val = {nib_ff, s_h};
         end else begin
            s_val = {4'h0, nib_ff};
            s_again = 1'b1;
         end
      end else begin
         s_qs_next = 1'b0;
         if (!(qs_ff && s_c == CH_QUESTION) && !s_sep) begin
            if (s_c == CH_QUESTION) begin
               s_emit = 1'b1;
               s_qs_next = 1'b1;
            end else if (s_c == CH_QUOTE) begin
               s_open = 1'b1;
            end else if (s_hv) begin
               s_nib_load = 1'b1;
               s_pend_set = 1'b1;
            end
         end
      end
   end

   always_comb begin
      out_free = !out_valid_ff || rsp_ready;
      push_ok = !hold_valid_ff || out_free;

      em_valid = 1'b0;
      em_val = 8'h00;
      em_mask = MASK_EXACT;
      if (cmd.step && s_emit) begin
         em_valid = 1'b1;
         em_val = s_val;
         em_mask = s_mask;
      end else if (cmd.emit_rd) begin
         em_valid = 1'b1;
         em_val = rd_data_ff;
      end else if (cmd.flush_nib) begin
         em_valid = 1'b1;
         em_val = {4'h0, nib_ff};
      end
   end

   always_comb begin
      char_in = char_ff;
      end_in = end_ff;
      nib_in = nib_ff;
      pend_in = pend_ff;
      qs_in = qs_ff;
      inside_in = inside_ff;
      len_in = len_ff;
      ovf_in = ovf_ff;
      idx_in = idx_ff;
      rep_in = rep_ff;
      hold_valid_in = hold_valid_ff;
      hold_value_in = hold_value_ff;
      hold_mask_in = hold_mask_ff;
      hold_ovf_in = hold_ovf_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_value_in = out_value_ff;
      out_mask_in = out_mask_ff;
      out_has_in = out_has_ff;
      out_ovf_in = out_ovf_ff;
      out_last_in = out_last_ff;

      if (cmd.capture) begin
         char_in = req_char_code;
         end_in = req_end_of_text;
      end
      if (cmd.step) begin
         qs_in = s_qs_next;
         if (s_nib_load) nib_in = s_h;
         if (s_pend_set) pend_in = 1'b1;
         if (s_pend_clr) pend_in = 1'b0;
         if (s_open) begin
            inside_in = 1'b1;
            len_in = '0;
         end
      end
      if (cmd.flush_nib) pend_in = 1'b0;
      if (cmd.store) begin
         if (len_ff < LW'(MAX_TEXT)) begin
            len_in = len_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.quote_end) begin
         inside_in = 1'b0;
         len_in = '0;
      end
      if (cmd.rep_start) begin
         inside_in = 1'b0;
         rep_in = 1'b1;
      end
      if (cmd.idx_clr || cmd.rep_start) idx_in = '0;
      if (cmd.idx_inc) idx_in = idx_ff + 1'b1;

      // new result goes to the held slot, the held one moves on
      if (em_valid) begin
         if (hold_valid_ff) begin
            out_valid_in = 1'b1;
            out_value_in = hold_value_ff;
            out_mask_in = hold_mask_ff;
            out_has_in = 1'b1;
            out_ovf_in = hold_ovf_ff;
            out_last_in = 1'b0;
         end
         hold_valid_in = 1'b1;
         hold_value_in = em_val;
         hold_mask_in = em_mask;
         hold_ovf_in = ovf_ff;
      end
      if (cmd.release_mid && hold_valid_ff) begin
         out_valid_in = 1'b1;
         out_value_in = hold_value_ff;
         out_mask_in = hold_mask_ff;
         out_has_in = 1'b1;
         out_ovf_in = hold_ovf_ff;
         out_last_in = 1'b0;
         hold_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         out_valid_in = 1'b1;
         out_last_in = 1'b1;
         if (hold_valid_ff) begin
            out_value_in = hold_value_ff;
            out_mask_in = hold_mask_ff;
            out_has_in = 1'b1;
            out_ovf_in = hold_ovf_ff;
         end else begin
            // end marker
            out_value_in = 8'h00;
            out_mask_in = MASK_WILD;
            out_has_in = 1'b0;
            out_ovf_in = ovf_ff;
         end
         hold_valid_in = 1'b0;
         nib_in = 4'h0;
         pend_in = 1'b0;
         qs_in = 1'b0;
         inside_in = 1'b0;
         len_in = '0;
         ovf_in = 1'b0;
         rep_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store && len_ff < LW'(MAX_TEXT)) begin
         mem[len_ff[AW-1:0]] <= char_ff;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      end_ff <= end_in;
      hold_value_ff <= hold_value_in;
      hold_mask_ff <= hold_mask_in;
      hold_ovf_ff <= hold_ovf_in;
      out_value_ff <= out_value_in;
      out_mask_ff <= out_mask_in;
      out_has_ff <= out_has_in;
      out_ovf_ff <= out_ovf_in;
      out_last_ff <= out_last_in;
      if (reset) begin
         nib_ff <= 4'h0;
         pend_ff <= 1'b0;
         qs_ff <= 1'b0;
         inside_ff <= 1'b0;
         len_ff <= '0;
         ovf_ff <= 1'b0;
         idx_ff <= '0;
         rep_ff <= 1'b0;
         hold_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         nib_ff <= nib_in;
         pend_ff <= pend_in;
         qs_ff <= qs_in;
         inside_ff <= inside_in;
         len_ff <= len_in;
         ovf_ff <= ovf_in;
         idx_ff <= idx_in;
         rep_ff <= rep_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      sts.quote_open = inside_ff;
      sts.char_quote = (char_ff == CH_QUOTE);
      sts.len_zero = (len_ff == '0);
      sts.idx_last = ((LW'(idx_ff) + 1'b1) == len_ff);
      sts.end_flag = end_ff;
      sts.step_emit = s_emit;
      sts.step_again = s_again;
      sts.push_ok = push_ok;
      sts.out_free = out_free;
      sts.pend = pend_ff;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_pattern_value = out_value_ff;
   assign rsp_pattern_mask = out_mask_ff;
   assign rsp_has_byte = out_has_ff;
   assign rsp_text_overflow = out_ovf_ff;
   assign rsp_last = out_last_ff;

endmodule

`default_nettype wire

// File: src/bpt_controller.sv
// ----------------------------------------------------------------------------
// bpt_controller - sequencing state machine of the pattern parser
// walks each character, quote flushes and end-of-text reparse
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpt_controller (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   output bpt_pkg::bpt_cmd_type cmd,
   input  bpt_pkg::bpt_sts_type sts
);
   import bpt_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_CHAR     = 4'd1;
   localparam logic [3:0] S_FLUSH_RD = 4'd2;
   localparam logic [3:0] S_FLUSH_EM = 4'd3;
   localparam logic [3:0] S_FIN      = 4'd4;
   localparam logic [3:0] S_REP_RD   = 4'd5;
   localparam logic [3:0] S_REP_CH   = 4'd6;
   localparam logic [3:0] S_END      = 4'd7;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_CHAR;
            end
         end
         S_CHAR: begin
            if (sts.quote_open) begin
               if (sts.char_quote) begin
                  if (sts.len_zero) begin
                     cmd.quote_end = 1'b1;
                     state_in = S_FIN;
                  end else begin
                     cmd.idx_clr = 1'b1;
                     state_in = S_FLUSH_RD;
                  end
               end else begin
                  cmd.store = 1'b1;
                  state_in = S_FIN;
               end
            end else if (!sts.step_emit || sts.push_ok) begin
               cmd.step = 1'b1;
               if (!sts.step_again) state_in = S_FIN;
            end
         end
         S_FLUSH_RD: begin
            cmd.mem_rd = 1'b1;
            state_in = S_FLUSH_EM;
         end
         S_FLUSH_EM: begin
            if (sts.push_ok) begin
               cmd.emit_rd = 1'b1;
               if (sts.idx_last) begin
                  cmd.quote_end = 1'b1;
                  state_in = S_FIN;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in = S_FLUSH_RD;
               end
            end
         end
         S_FIN: begin
            if (sts.end_flag) begin
               if (sts.quote_open) begin
                  cmd.rep_start = 1'b1;
                  state_in = sts.len_zero ? S_END : S_REP_RD;
               end else begin
                  state_in = S_END;
               end
            end else if (sts.push_ok) begin
               cmd.release_mid = 1'b1;
               req_ready = 1'b1;
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in = S_CHAR;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_REP_RD: begin
            cmd.mem_rd = 1'b1;
            state_in = S_REP_CH;
         end
         S_REP_CH: begin
            if (!sts.step_emit || sts.push_ok) begin
               cmd.step = 1'b1;
               if (!sts.step_again) begin
                  if (sts.idx_last) begin
                     state_in = S_END;
                  end else begin
                     cmd.idx_inc = 1'b1;
                     state_in = S_REP_RD;
                  end
               end
            end
         end
         S_END: begin
            if (sts.pend) begin
               if (sts.push_ok) cmd.flush_nib = 1'b1;
            end else if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: src/bpt_checker.sv
// ----------------------------------------------------------------------------
// bpt_checker - port level checks of the byte pattern text parser
// result beat rules seen from the top level ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpt_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [7:0] rsp_pattern_value,
   input wire [7:0] rsp_pattern_mask,
   input wire       rsp_has_byte,
   input wire       rsp_last
);
   import bpt_pkg::*;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pattern_value)
         && $stable(rsp_pattern_mask) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   // end marker only closes a string and carries no byte
   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_byte |-> rsp_last && rsp_pattern_value == 8'h00
         && rsp_pattern_mask == MASK_WILD)
      else $error("malformed end marker");

   // a byte is either wildcard or exact
   a_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_byte |->
         rsp_pattern_mask == MASK_WILD || rsp_pattern_mask == MASK_EXACT)
      else $error("mask neither wildcard nor exact");

   // wildcards compare against zero
   a_wild_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pattern_mask == MASK_WILD |-> rsp_pattern_value == 8'h00)
      else $error("wildcard with non-zero value");

   // reset empties the result stage
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind byte_pattern_text_parser_core bpt_checker u_bpt_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_pattern_value (rsp_pattern_value),
   .rsp_pattern_mask  (rsp_pattern_mask),
   .rsp_has_byte      (rsp_has_byte),
   .rsp_last          (rsp_last)
);

`default_nettype wire
